>>> rtl/core/tcdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcdr_pkg - shared definitions for the text cell dirty rectangle tracker
// Screen geometry, field widths, codes, the result record and the bitmap
// helper functions used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package tcdr_pkg;

  localparam int TEXT_COLUMNS = 32;
  localparam int TEXT_ROWS    = 24;
  localparam int CHUNK_ROWS   = 12;
  localparam int CELL_PIXELS  = 10;

  localparam int COL_AW = $clog2(TEXT_COLUMNS);
  localparam int ROW_AW = $clog2(TEXT_ROWS);

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int CELL_W   = 5;
  localparam int KIND_W   = 2;
  localparam int GLYPH_W  = 7;
  localparam int ATTR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int WIDTH_W  = 6;
  localparam int HEIGHT_W = 4;
  localparam int WCOL_W   = 8;
  localparam int WPAGE_W  = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'd127;

  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

  localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'd8;
  localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'd0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_FLUSH  = 2'd1,
    OP_REDRAW = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITTEN = 2'd0,
    KIND_IGNORED = 2'd1,
    KIND_REGION  = 2'd2,
    KIND_CLEAN   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [GLYPH_W-1:0]   glyph_index;
    logic [ATTR_W-1:0]    attribute;
    logic [CELL_W-1:0]    region_column;
    logic [CELL_W-1:0]    region_row;
    logic [WIDTH_W-1:0]   region_width;
    logic [HEIGHT_W-1:0]  region_height;
    logic [WCOL_W-1:0]    window_col_start;
    logic [WCOL_W-1:0]    window_col_end;
    logic [WPAGE_W-1:0]   window_page_start;
    logic [WPAGE_W-1:0]   window_page_end;
    logic                 last;
  } res_t;

  // lowest set bit of a bitmap row
  function automatic logic [COL_AW-1:0] first_set(input logic [TEXT_COLUMNS-1:0] bits);
    logic [COL_AW-1:0] idx;
    idx = '0;
    for (int i = TEXT_COLUMNS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        idx = COL_AW'(i);
      end
    end
    return idx;
  endfunction

  // run of set bits that starts just right of pos
  function automatic logic [COL_AW:0] ones_above(input logic [TEXT_COLUMNS-1:0] bits,
                                                 input logic [COL_AW-1:0] pos);
    logic [TEXT_COLUMNS-1:0] s;
    logic [COL_AW:0]         cnt;
    s   = bits >> ({1'b0, pos} + (COL_AW+1)'(1));
    cnt = (COL_AW+1)'(TEXT_COLUMNS);
    for (int i = TEXT_COLUMNS - 1; i >= 0; i--) begin
      if (!s[i]) begin
        cnt = (COL_AW+1)'(i);
      end
    end
    return cnt;
  endfunction

  // columns pos .. pos+w-1 set
  function automatic logic [TEXT_COLUMNS-1:0] span_mask(input logic [COL_AW-1:0] pos,
                                                        input logic [WIDTH_W-1:0] w);
    logic [TEXT_COLUMNS-1:0] m;
    logic [WIDTH_W:0]        lim;
    lim = {1'b0, (WIDTH_W)'(pos)} + {1'b0, w};
    for (int i = 0; i < TEXT_COLUMNS; i++) begin
      m[i] = ((WIDTH_W+1)'(i) >= (WIDTH_W+1)'(pos)) && ((WIDTH_W+1)'(i) < lim);
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/tcdr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcdr_if - channel interfaces of the text cell dirty rectangle tracker
// Request, result and register write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface tcdr_in_if;
  logic                              valid;
  logic                              ready;
  logic [tcdr_pkg::OPCODE_W-1:0]     opcode;
  logic [tcdr_pkg::CHAR_W-1:0]       character;
  logic                              invert;
  logic [tcdr_pkg::CELL_W-1:0]       column;
  logic [tcdr_pkg::CELL_W-1:0]       row;

  modport source (output valid, output opcode, output character, output invert,
                  output column, output row, input ready);
  modport sink   (input valid, input opcode, input character, input invert,
                  input column, input row, output ready);
endinterface

interface tcdr_out_if;
  logic                              valid;
  logic                              ready;
  logic [tcdr_pkg::KIND_W-1:0]       kind;
  logic [tcdr_pkg::GLYPH_W-1:0]      glyph_index;
  logic [tcdr_pkg::ATTR_W-1:0]       attribute;
  logic [tcdr_pkg::CELL_W-1:0]       region_column;
  logic [tcdr_pkg::CELL_W-1:0]       region_row;
  logic [tcdr_pkg::WIDTH_W-1:0]      region_width;
  logic [tcdr_pkg::HEIGHT_W-1:0]     region_height;
  logic [tcdr_pkg::WCOL_W-1:0]       window_col_start;
  logic [tcdr_pkg::WCOL_W-1:0]       window_col_end;
  logic [tcdr_pkg::WPAGE_W-1:0]      window_page_start;
  logic [tcdr_pkg::WPAGE_W-1:0]      window_page_end;
  logic                              last;

  modport source (output valid, output kind, output glyph_index, output attribute,
                  output region_column, output region_row, output region_width,
                  output region_height, output window_col_start, output window_col_end,
                  output window_page_start, output window_page_end, output last,
                  input ready);
  modport sink   (input valid, input kind, input glyph_index, input attribute,
                  input region_column, input region_row, input region_width,
                  input region_height, input window_col_start, input window_col_end,
                  input window_page_start, input window_page_end, input last,
                  output ready);
endinterface

interface tcdr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tcdr_pkg::CFG_IDX_W-1:0]    index;
  logic [tcdr_pkg::COLOR_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/text_cell_dirty_rectangle_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_cell_dirty_rectangle_tracker - dirty cell bitmap with rectangle flush
// Marks written cells dirty, coalesces dirty cells into one rectangle per flush
// and emits it, or the whole screen on redraw, in chunks with their
// rotated pixel windows.
// ----------------------------------------------------------------------------
// The bitmap is one row of cells per word in a single memory with one read
// and one write port; a per-row valid bit, cleared by reset, makes unwritten
// rows read as clean, so the block takes requests straight after reset. One
// request is handled at a time. A write reads its row, then sets the cell and
// loads its result in S_WR_MOD once the output register is free. A flush
// sweeps the memory one row per cycle: S_SCAN looks for the first dirty row,
// S_DOWN grows the rectangle downward while its first column stays dirty,
// S_CLR_RD re-addresses the top row and S_CLEAR clears the rectangle row by
// row; S_EMIT then emits it in chunks, holding while the output is stalled.
// A redraw goes straight to S_EMIT with the whole screen. The next request is
// accepted while the last result still waits at the output register.
// ----------------------------------------------------------------------------
module text_cell_dirty_rectangle_tracker (
  input  logic          clk,
  input  logic          rst_n,
  tcdr_in_if.sink       in_req,
  tcdr_out_if.source    out_res,
  tcdr_cfg_if.sink      cfg_wr
);

  localparam int CW = tcdr_pkg::COL_AW;
  localparam int RW = tcdr_pkg::ROW_AW;
  localparam int HW = tcdr_pkg::ROW_AW + 1;
  localparam int WW = tcdr_pkg::WIDTH_W;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WR_MOD = 8'b0000_0010,
    S_SIMPLE = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DOWN   = 8'b0001_0000,
    S_CLR_RD = 8'b0010_0000,
    S_CLEAR  = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [tcdr_pkg::TEXT_COLUMNS-1:0] dirty_mem [tcdr_pkg::TEXT_ROWS];
  logic [tcdr_pkg::TEXT_ROWS-1:0]    row_vld_r;
  logic [tcdr_pkg::TEXT_COLUMNS-1:0] rd_data_r;
  logic                              rd_vld_r;
  logic [RW-1:0]                     rd_addr;
  logic                              wr_en;
  logic [RW-1:0]                     wr_addr;
  logic [tcdr_pkg::TEXT_COLUMNS-1:0] wr_data;
  logic [tcdr_pkg::TEXT_COLUMNS-1:0] row_q;

  logic [RW-1:0]                     cur_r, cur_nxt, cur_inc;
  logic [CW-1:0]                     x_r, x_nxt;
  logic [RW-1:0]                     y_r, y_nxt;
  logic [HW-1:0]                     h_r, h_nxt;
  logic [WW-1:0]                     w_r, w_nxt;
  logic [tcdr_pkg::GLYPH_W-1:0]      glyph_r, glyph_nxt;
  logic [tcdr_pkg::ATTR_W-1:0]       attr_r, attr_nxt;
  tcdr_pkg::kind_t                   kind_r, kind_nxt;
  logic [tcdr_pkg::COLOR_W-1:0]      fg_r, bg_r;

  tcdr_pkg::res_t                    out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              slot_free;

  logic                              wr_ok;
  logic                              cur_last;
  logic [CW-1:0]                     fs;
  logic [WW-1:0]                     run_cand;
  logic [HW-1:0]                     y_end;
  logic [tcdr_pkg::HEIGHT_W-1:0]     sh;
  logic [HW-1:0]                     span_rows;
  logic [9:0]                        col_start, col_end, page_start, page_end;

  assign row_q     = rd_vld_r ? rd_data_r : '0;
  assign cur_last  = (cur_r == RW'(tcdr_pkg::TEXT_ROWS - 1));
  assign cur_inc   = cur_last ? '0 : cur_r + RW'(1);
  assign slot_free = !out_valid_r || out_res.ready;
  assign wr_ok     = (in_req.character >= tcdr_pkg::CHAR_FIRST)
                     && (in_req.character <= tcdr_pkg::CHAR_LAST)
                     && ({1'b0, in_req.row} < (tcdr_pkg::CELL_W+1)'(tcdr_pkg::TEXT_ROWS))
                     && ({1'b0, in_req.column}
                         < (tcdr_pkg::CELL_W+1)'(tcdr_pkg::TEXT_COLUMNS));
  assign fs        = tcdr_pkg::first_set(row_q);
  assign run_cand  = (state_r == S_SCAN) ? WW'(tcdr_pkg::ones_above(row_q, fs)) + WW'(1)
                                         : WW'(tcdr_pkg::ones_above(row_q, x_r)) + WW'(1);
  assign y_end     = HW'(y_r) + h_r - HW'(1);

  // chunk geometry
  assign sh         = (h_r > HW'(tcdr_pkg::CHUNK_ROWS)) ? tcdr_pkg::HEIGHT_W'(tcdr_pkg::CHUNK_ROWS)
                                                        : tcdr_pkg::HEIGHT_W'(h_r);
  assign span_rows  = HW'(tcdr_pkg::TEXT_ROWS) - HW'(sh) - HW'(y_r);
  assign col_start  = 10'(span_rows) * 10'(tcdr_pkg::CELL_PIXELS);
  assign col_end    = col_start + 10'(sh) * 10'(tcdr_pkg::CELL_PIXELS) - 10'd1;
  assign page_start = 10'(x_r) * 10'(tcdr_pkg::CELL_PIXELS);
  assign page_end   = page_start + 10'(w_r) * 10'(tcdr_pkg::CELL_PIXELS) - 10'd1;

  assign in_req.ready = (state_r == S_IDLE);
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    glyph_nxt     = glyph_r;
    attr_nxt      = attr_r;
    kind_nxt      = kind_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = cur_r;
    wr_data       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          unique case (tcdr_pkg::opcode_t'(in_req.opcode))
            tcdr_pkg::OP_WRITE: begin
              if (wr_ok) begin
                rd_addr   = RW'(in_req.row);
                x_nxt     = CW'(in_req.column);
                y_nxt     = RW'(in_req.row);
                glyph_nxt = tcdr_pkg::GLYPH_W'(in_req.character - tcdr_pkg::CHAR_FIRST);
                attr_nxt  = in_req.invert ? {bg_r, fg_r} : {fg_r, bg_r};
                state_nxt = S_WR_MOD;
              end else begin
                kind_nxt  = tcdr_pkg::KIND_IGNORED;
                state_nxt = S_SIMPLE;
              end
            end
            tcdr_pkg::OP_FLUSH: begin
              rd_addr   = '0;
              cur_nxt   = '0;
              state_nxt = S_SCAN;
            end
            tcdr_pkg::OP_REDRAW: begin
              x_nxt     = '0;
              y_nxt     = '0;
              w_nxt     = WW'(tcdr_pkg::TEXT_COLUMNS);
              h_nxt     = HW'(tcdr_pkg::TEXT_ROWS);
              state_nxt = S_EMIT;
            end
            tcdr_pkg::OP_RSVD: begin
              kind_nxt  = tcdr_pkg::KIND_IGNORED;
              state_nxt = S_SIMPLE;
            end
          endcase
        end
      end

      S_WR_MOD: begin
        rd_addr = y_r;
        if (slot_free) begin
          wr_en                 = 1'b1;
          wr_addr               = y_r;
          wr_data               = row_q | (tcdr_pkg::TEXT_COLUMNS'(1) << x_r);
          out_nxt               = '0;
          out_nxt.kind          = tcdr_pkg::KIND_WRITTEN;
          out_nxt.glyph_index   = glyph_r;
          out_nxt.attribute     = attr_r;
          out_nxt.last          = 1'b1;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end

      S_SIMPLE: begin
        if (slot_free) begin
          out_nxt       = '0;
          out_nxt.kind  = kind_r;
          out_nxt.last  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_SCAN: begin
        rd_addr = cur_inc;
        if (row_q != '0) begin
          x_nxt = fs;
          y_nxt = cur_r;
          h_nxt = HW'(1);
          w_nxt = run_cand;
          if (cur_last) begin
            state_nxt = S_CLR_RD;
          end else begin
            cur_nxt   = cur_inc;
            state_nxt = S_DOWN;
          end
        end else if (cur_last) begin
          kind_nxt  = tcdr_pkg::KIND_CLEAN;
          state_nxt = S_SIMPLE;
        end else begin
          cur_nxt = cur_inc;
        end
      end

      S_DOWN: begin
        rd_addr = cur_inc;
        if (row_q[x_r]) begin
          h_nxt = h_r + HW'(1);
          if (run_cand < w_r) begin
            w_nxt = run_cand;
          end
          if (cur_last) begin
            state_nxt = S_CLR_RD;
          end else begin
            cur_nxt = cur_inc;
          end
        end else begin
          state_nxt = S_CLR_RD;
        end
      end

      S_CLR_RD: begin
        rd_addr   = y_r;
        cur_nxt   = y_r;
        state_nxt = S_CLEAR;
      end

      S_CLEAR: begin
        rd_addr = cur_inc;
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = row_q & ~tcdr_pkg::span_mask(x_r, w_r);
        if (HW'(cur_r) == y_end) begin
          state_nxt = S_EMIT;
        end else begin
          cur_nxt = cur_inc;
        end
      end

      S_EMIT: begin
        if (slot_free) begin
          out_nxt                   = '0;
          out_nxt.kind              = tcdr_pkg::KIND_REGION;
          out_nxt.region_column     = tcdr_pkg::CELL_W'(x_r);
          out_nxt.region_row        = tcdr_pkg::CELL_W'(y_r);
          out_nxt.region_width      = w_r;
          out_nxt.region_height     = sh;
          out_nxt.window_col_start  = col_start[tcdr_pkg::WCOL_W-1:0];
          out_nxt.window_col_end    = col_end[tcdr_pkg::WCOL_W-1:0];
          out_nxt.window_page_start = page_start[tcdr_pkg::WPAGE_W-1:0];
          out_nxt.window_page_end   = page_end[tcdr_pkg::WPAGE_W-1:0];
          out_nxt.last              = (h_r <= HW'(tcdr_pkg::CHUNK_ROWS));
          out_valid_nxt             = 1'b1;
          y_nxt                     = y_r + RW'(sh);
          h_nxt                     = h_r - HW'(sh);
          if (h_r <= HW'(tcdr_pkg::CHUNK_ROWS)) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      dirty_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= dirty_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      rd_vld_r    <= 1'b0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fg_r        <= tcdr_pkg::FOREGROUND_RESET;
      bg_r        <= tcdr_pkg::BACKGROUND_RESET;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r    <= row_vld_r[rd_addr];
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr.valid) begin
        priority if (cfg_wr.index == tcdr_pkg::CFG_FOREGROUND) begin
          fg_r <= cfg_wr.data;
        end else if (cfg_wr.index == tcdr_pkg::CFG_BACKGROUND) begin
          bg_r <= cfg_wr.data;
        end else begin
          fg_r <= fg_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    h_r     <= h_nxt;
    w_r     <= w_nxt;
    glyph_r <= glyph_nxt;
    attr_r  <= attr_nxt;
    kind_r  <= kind_nxt;
    out_r   <= out_nxt;
  end

  assign out_res.valid             = out_valid_r;
  assign out_res.kind              = out_r.kind;
  assign out_res.glyph_index       = out_r.glyph_index;
  assign out_res.attribute         = out_r.attribute;
  assign out_res.region_column     = out_r.region_column;
  assign out_res.region_row        = out_r.region_row;
  assign out_res.region_width      = out_r.region_width;
  assign out_res.region_height     = out_r.region_height;
  assign out_res.window_col_start  = out_r.window_col_start;
  assign out_res.window_col_end    = out_r.window_col_end;
  assign out_res.window_page_start = out_r.window_page_start;
  assign out_res.window_page_end   = out_r.window_page_end;
  assign out_res.last              = out_r.last;

endmodule
`default_nettype wire
